FILE: src/mwct_pkg.sv
// Package for the minimum covering window block: field widths, default sizes,
// request and result payload structs, and the sequencer state type.
// Used by src/min_window_covering_terms.sv; depends on nothing else.
package mwct_pkg;

    localparam int POSITION_BITS       = 30;
    localparam int LEN_BITS            = POSITION_BITS + 1;
    localparam int TERM_BITS           = 4;
    localparam int TERM_COUNT_BITS     = 5;
    localparam int MAX_TERMS_DEFAULT   = 16;
    localparam int STORE_DEPTH_DEFAULT = 1024;

    typedef struct packed {
        logic [TERM_BITS-1:0]     term;
        logic [POSITION_BITS-1:0] position;
        logic                     last_of_term;
    } in_item_t;

    typedef struct packed {
        logic [LEN_BITS-1:0] window_length;
        logic                error;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_INIT_RD,
        ST_INIT_WR,
        ST_SCAN,
        ST_STEP,
        ST_FETCH
    } state_t;

endpackage

FILE: src/min_window_covering_terms.sv
// Top level of the minimum covering window block: position store, per-term
// tables and the merge sequencer with its shared compare unit.
// Depends on mwct_pkg (src/mwct_pkg.sv).
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+---------------------------------
//  request  | in        | s_valid / s_ready | s_data: term, position, last flag
//  result   | out       | m_valid / m_ready | m_data: window_length, error
//  config   | in        | cfg_we            | cfg_wdata: term_count
//
// Loading takes one request per cycle while no waiting result holds it off, and
// writes each position to the store until it is full. After the last position of
// the last term the merge runs with s_ready low: a read and a write state fetch the
// first head of each of k terms, then each merge step scans the k heads through the
// shared compare unit, updates the window and reads the store, with at most one step per stored position.
// Reset is synchronous and takes effect at once; the stores need no clearing.
// A waiting result holds off the next request only until m_ready is seen.
module min_window_covering_terms #(
    parameter int MAX_TERMS   = mwct_pkg::MAX_TERMS_DEFAULT,
    parameter int STORE_DEPTH = mwct_pkg::STORE_DEPTH_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [mwct_pkg::TERM_COUNT_BITS-1:0]  cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  mwct_pkg::in_item_t                    s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output mwct_pkg::out_item_t                   m_data
);

    localparam int TIDX_BITS = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNT_BITS  = $clog2(MAX_TERMS + 1);
    localparam int ADDR_BITS = $clog2(STORE_DEPTH);
    localparam int CUR_BITS  = $clog2(STORE_DEPTH + 1);
    localparam int PB        = mwct_pkg::POSITION_BITS;
    localparam int LB        = mwct_pkg::LEN_BITS;

    mwct_pkg::state_t state_reg, state_next;

    logic [mwct_pkg::TERM_COUNT_BITS-1:0] term_count_reg;
    logic [TIDX_BITS-1:0] loading_term_reg, loading_term_next;
    logic [CUR_BITS-1:0]  load_count_reg, load_count_next;
    logic                 fault_reg, fault_next;
    logic [TIDX_BITS-1:0] idx_reg, idx_next;
    logic [TIDX_BITS-1:0] min_idx_reg, min_idx_next;
    logic [PB-1:0]        min_val_reg, min_val_next;
    logic [PB-1:0]        largest_reg, largest_next;
    logic [LB-1:0]        best_reg, best_next;
    logic [CNT_BITS-1:0]  merge_cnt_reg, merge_cnt_next;
    logic                 m_valid_reg, m_valid_next;
    mwct_pkg::out_item_t  m_data_reg, m_data_next;
    logic [PB-1:0]        rdata_reg;

    logic [PB-1:0]        pos_mem [STORE_DEPTH];
    logic [ADDR_BITS-1:0] start_mem [MAX_TERMS];
    logic [CUR_BITS-1:0]  len_mem [MAX_TERMS];
    logic [CUR_BITS-1:0]  cursor_mem [MAX_TERMS];
    logic [PB-1:0]        head_mem [MAX_TERMS];

    logic                 accept;
    logic                 store_full;
    logic                 term_miss;
    logic [CNT_BITS-1:0]  active_cnt;
    logic [TIDX_BITS-1:0] len_ra;
    logic [TIDX_BITS-1:0] start_ra;
    logic [CUR_BITS-1:0]  len_sel;
    logic [ADDR_BITS-1:0] start_sel;
    logic [CUR_BITS-1:0]  len_after;
    logic [TIDX_BITS:0]   lt_next;
    logic                 more_terms;
    logic                 fault_now;
    logic [PB-1:0]        head_scan;
    logic                 scan_less;
    logic                 idx_last;
    logic [LB-1:0]        cand_len;
    logic [LB-1:0]        best_min;
    logic [CUR_BITS-1:0]  cur_next;
    logic                 merge_end;
    logic [PB-1:0]        largest_max;
    logic [ADDR_BITS-1:0] rd_addr;
    logic                 len0_clear;

    // Term count as used: zero acts as one, anything above the table size saturates.
    always_comb begin
        if (term_count_reg == '0) begin
            active_cnt = CNT_BITS'(1);
        end else if (32'(term_count_reg) > 32'(MAX_TERMS)) begin
            active_cnt = CNT_BITS'(MAX_TERMS);
        end else begin
            active_cnt = CNT_BITS'(term_count_reg);
        end
    end

    assign s_ready    = (state_reg == mwct_pkg::ST_LOAD) && (!m_valid_reg || m_ready);
    assign accept     = s_valid && s_ready;
    assign store_full = (load_count_reg == CUR_BITS'(STORE_DEPTH));
    assign term_miss  = (32'(s_data.term) != 32'(loading_term_reg));

    // The length and start tables each have a single read port.
    assign len_ra    = (state_reg == mwct_pkg::ST_LOAD) ? loading_term_reg : min_idx_reg;
    assign start_ra  = (state_reg == mwct_pkg::ST_INIT_RD) ? idx_reg : min_idx_reg;
    assign len_sel   = len_mem[len_ra];
    assign start_sel = start_mem[start_ra];

    assign len_after  = store_full ? len_sel : len_sel + CUR_BITS'(1);
    assign lt_next    = {1'b0, loading_term_reg} + (TIDX_BITS + 1)'(1);
    assign more_terms = (32'(lt_next) < 32'(active_cnt));
    assign fault_now  = fault_reg || term_miss || store_full
                        || (s_data.last_of_term && (len_after == '0));

    assign head_scan   = head_mem[idx_reg];
    assign scan_less   = (idx_reg == '0) || (head_scan < min_val_reg);
    assign idx_last    = ((32'(idx_reg) + 1) >= 32'(merge_cnt_reg));
    assign cand_len    = {1'b0, largest_reg} - {1'b0, min_val_reg} + LB'(1);
    assign best_min    = (cand_len < best_reg) ? cand_len : best_reg;
    assign cur_next    = cursor_mem[min_idx_reg] + CUR_BITS'(1);
    assign merge_end   = (cur_next >= len_sel);
    assign largest_max = (rdata_reg > largest_reg) ? rdata_reg : largest_reg;

    assign rd_addr = (state_reg == mwct_pkg::ST_INIT_RD)
                     ? start_sel
                     : start_sel + cur_next[ADDR_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= mwct_pkg::ST_LOAD;
            term_count_reg   <= mwct_pkg::TERM_COUNT_BITS'(1);
            loading_term_reg <= '0;
            load_count_reg   <= '0;
            fault_reg        <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            loading_term_reg <= loading_term_next;
            load_count_reg   <= load_count_next;
            fault_reg        <= fault_next;
            m_valid_reg      <= m_valid_next;
            if (cfg_we) begin
                term_count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        min_idx_reg   <= min_idx_next;
        min_val_reg   <= min_val_next;
        largest_reg   <= largest_next;
        best_reg      <= best_next;
        merge_cnt_reg <= merge_cnt_next;
        m_data_reg    <= m_data_next;
    end

    always_comb begin
        state_next        = state_reg;
        loading_term_next = loading_term_reg;
        load_count_next   = load_count_reg;
        fault_next        = fault_reg;
        idx_next          = idx_reg;
        min_idx_next      = min_idx_reg;
        min_val_next      = min_val_reg;
        largest_next      = largest_reg;
        best_next         = best_reg;
        merge_cnt_next    = merge_cnt_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_data_next       = m_data_reg;
        len0_clear        = 1'b0;

        case (state_reg)
            mwct_pkg::ST_LOAD: begin
                if (accept) begin
                    fault_next = fault_now;
                    if (!store_full) begin
                        load_count_next = load_count_reg + CUR_BITS'(1);
                    end
                    if (s_data.last_of_term) begin
                        if (more_terms) begin
                            loading_term_next = lt_next[TIDX_BITS-1:0];
                        end else begin
                            loading_term_next = '0;
                            load_count_next   = '0;
                            fault_next        = 1'b0;
                            if (fault_now) begin
                                m_valid_next              = 1'b1;
                                m_data_next.window_length = '0;
                                m_data_next.error         = 1'b1;
                                len0_clear                = 1'b1;
                            end else begin
                                state_next     = mwct_pkg::ST_INIT_RD;
                                idx_next       = '0;
                                largest_next   = '0;
                                best_next      = '1;
                                merge_cnt_next = active_cnt;
                            end
                        end
                    end
                end
            end
            mwct_pkg::ST_INIT_RD: begin
                state_next = mwct_pkg::ST_INIT_WR;
            end
            mwct_pkg::ST_INIT_WR: begin
                largest_next = largest_max;
                if (idx_last) begin
                    idx_next   = '0;
                    state_next = mwct_pkg::ST_SCAN;
                end else begin
                    idx_next   = idx_reg + TIDX_BITS'(1);
                    state_next = mwct_pkg::ST_INIT_RD;
                end
            end
            mwct_pkg::ST_SCAN: begin
                // Strict compare keeps the lowest index among tied heads.
                if (scan_less) begin
                    min_val_next = head_scan;
                    min_idx_next = idx_reg;
                end
                if (idx_last) begin
                    state_next = mwct_pkg::ST_STEP;
                end else begin
                    idx_next = idx_reg + TIDX_BITS'(1);
                end
            end
            mwct_pkg::ST_STEP: begin
                best_next = best_min;
                if (merge_end) begin
                    m_valid_next              = 1'b1;
                    m_data_next.window_length = best_min;
                    m_data_next.error         = 1'b0;
                    len0_clear                = 1'b1;
                    state_next                = mwct_pkg::ST_LOAD;
                end else begin
                    state_next = mwct_pkg::ST_FETCH;
                end
            end
            mwct_pkg::ST_FETCH: begin
                largest_next = largest_max;
                idx_next     = '0;
                state_next   = mwct_pkg::ST_SCAN;
            end
            default: begin
                state_next = mwct_pkg::ST_LOAD;
            end
        endcase
    end

    // Position store: one write port for loading, one registered read port for the merge.
    always_ff @(posedge aclk) begin
        if (accept && !store_full) begin
            pos_mem[load_count_reg[ADDR_BITS-1:0]] <= s_data.position;
        end
        rdata_reg <= pos_mem[rd_addr];
    end

    // Per-term tables. Only the length of term zero is defined after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_mem[0] <= '0;
        end else begin
            if (accept && !store_full) begin
                len_mem[loading_term_reg] <= len_after;
                if (len_sel == '0) begin
                    start_mem[loading_term_reg] <= load_count_reg[ADDR_BITS-1:0];
                end
            end
            if (accept && s_data.last_of_term && more_terms) begin
                len_mem[lt_next[TIDX_BITS-1:0]] <= '0;
            end
            if (len0_clear) begin
                len_mem[0] <= '0;
            end
            if (state_reg == mwct_pkg::ST_INIT_WR) begin
                head_mem[idx_reg]   <= rdata_reg;
                cursor_mem[idx_reg] <= '0;
            end
            if (state_reg == mwct_pkg::ST_STEP) begin
                cursor_mem[min_idx_reg] <= cur_next;
            end
            if (state_reg == mwct_pkg::ST_FETCH) begin
                head_mem[min_idx_reg] <= rdata_reg;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_load_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(load_count_reg) <= 32'(STORE_DEPTH))
        else $error("load count ran past the store depth");

    a_merge_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != mwct_pkg::ST_LOAD) |-> !m_valid_reg)
        else $error("result pending while the merge runs");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mwct_pkg::ST_SCAN) |-> (32'(idx_reg) < 32'(merge_cnt_reg)))
        else $error("scan index beyond the active terms");

    a_window_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mwct_pkg::ST_STEP) |-> (largest_reg >= min_val_reg))
        else $error("smallest head exceeds the largest head");

endmodule

FILE: verif/window_checker.sv
// Checker for the minimum covering window block: watches the config, request and
// result channels, predicts each result and compares it field by field.
// Depends on mwct_pkg (src/mwct_pkg.sv).
module window_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [mwct_pkg::TERM_COUNT_BITS-1:0] cfg_wdata,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  mwct_pkg::in_item_t                   s_data,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  mwct_pkg::out_item_t                  m_data,
    output int                                   outstanding,
    output int                                   fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TERMS = mwct_pkg::MAX_TERMS_DEFAULT;
    localparam int DEPTH = mwct_pkg::STORE_DEPTH_DEFAULT;

    logic [mwct_pkg::POSITION_BITS-1:0]   store_pos [DEPTH];
    int                                   list_start [TERMS];
    int                                   list_len [TERMS];
    int                                   cur_term;
    int                                   fill_count;
    bit                                   load_fault;
    logic [mwct_pkg::TERM_COUNT_BITS-1:0] term_count_q;
    mwct_pkg::out_item_t                  window_q [$];
    int                                   pending_n = 0;
    int                                   mismatches = 0;

    assign outstanding = pending_n;
    assign fail_count  = mismatches;

    task automatic clear_load();
        cur_term    = 0;
        fill_count  = 0;
        load_fault  = 1'b0;
        list_len[0] = 0;
    endtask

    // K-way merge over the loaded lists. The term with the smallest head is
    // advanced (lowest index on a tie) until that term's list runs out.
    function automatic logic [mwct_pkg::LEN_BITS-1:0] shortest_window(input int k);
        int                                 cursor [TERMS];
        logic [mwct_pkg::POSITION_BITS-1:0] head [TERMS];
        logic [mwct_pkg::POSITION_BITS-1:0] top_pos;
        logic [mwct_pkg::LEN_BITS-1:0]      best;
        logic [mwct_pkg::LEN_BITS-1:0]      span;
        int                                 lo;
        bit                                 done;
        top_pos = '0;
        best    = '1;
        done    = 1'b0;
        for (int t = 0; t < k; t++) begin
            cursor[t] = 0;
            head[t]   = store_pos[list_start[t]];
            if (head[t] > top_pos) top_pos = head[t];
        end
        while (!done) begin
            lo = 0;
            for (int t = 1; t < k; t++)
                if (head[t] < head[lo]) lo = t;
            span = {1'b0, top_pos} - {1'b0, head[lo]} + 31'd1;
            if (span < best) best = span;
            cursor[lo]++;
            if (cursor[lo] >= list_len[lo]) begin
                done = 1'b1;
            end else begin
                head[lo] = store_pos[(list_start[lo] + cursor[lo]) % DEPTH];
                if (head[lo] > top_pos) top_pos = head[lo];
            end
        end
        return best;
    endfunction

    always @(posedge aclk) begin : track_requests
        int                  k;
        int                  slot;
        mwct_pkg::out_item_t exp_item;
        if (!aresetn) begin
            term_count_q = 1;
            clear_load();
            window_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                k = (term_count_q == 0) ? 1 : ((term_count_q > TERMS) ? TERMS : term_count_q);
                slot = cur_term % TERMS;
                // A request tagged with another term still counts for the one loading.
                if (s_data.term != cur_term) load_fault = 1'b1;
                if (fill_count >= DEPTH) begin
                    load_fault = 1'b1;
                end else begin
                    if (list_len[slot] == 0) list_start[slot] = fill_count;
                    store_pos[fill_count] = s_data.position;
                    fill_count++;
                    list_len[slot]++;
                end
                if (s_data.last_of_term) begin
                    if (list_len[slot] == 0) load_fault = 1'b1;
                    cur_term++;
                    if (cur_term < k) begin
                        list_len[cur_term % TERMS] = 0;
                    end else begin
                        exp_item.error         = load_fault;
                        exp_item.window_length = load_fault ? '0 : shortest_window(k);
                        window_q.push_back(exp_item);
                        clear_load();
                    end
                end
            end

            // The block takes a new term count only after the request at the same edge.
            if (cfg_we) term_count_q = cfg_wdata;

            if (m_valid && m_ready) begin
                if (window_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with none expected: window_length %0d error %0b",
                             $time, m_data.window_length, m_data.error);
                end else begin
                    exp_item = window_q.pop_front();
                    if (m_data.error !== exp_item.error) begin
                        mismatches++;
                        $display("%0t: error flag expected %0b, got %0b",
                                 $time, exp_item.error, m_data.error);
                    end
                    if (m_data.window_length !== exp_item.window_length) begin
                        mismatches++;
                        $display("%0t: window_length expected %0d, got %0d",
                                 $time, exp_item.window_length, m_data.window_length);
                    end
                end
            end
        end
        pending_n <= window_q.size();
    end

endmodule

FILE: verif/testbench.sv
// Top of the minimum covering window testbench: clock, reset, config writes,
// request and result drivers, and the verdict.
// Depends on mwct_pkg, min_window_covering_terms and window_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int              PHASES        = 9;
    localparam int              PHASE_ITEMS   = 75;
    localparam int              HOLD_CYCLES   = 2000;
    localparam int              SETTLE_CYCLES = 20;
    localparam longint unsigned MAX_POS       = (64'd1 << mwct_pkg::POSITION_BITS) - 1;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
    typedef enum {SET_SORTED, SET_SCRAMBLED, SET_BAD_TERM, SET_NOISE} set_kind_t;

    logic                                 aclk = 1'b0;
    logic                                 aresetn = 1'b0;
    logic                                 cfg_we = 1'b0;
    logic [mwct_pkg::TERM_COUNT_BITS-1:0] cfg_wdata = '0;
    logic                                 s_valid = 1'b0;
    logic                                 s_ready;
    mwct_pkg::in_item_t                   s_data = '0;
    logic                                 m_valid;
    logic                                 m_ready = 1'b0;
    mwct_pkg::out_item_t                  m_data;
    int                                   outstanding;
    int                                   fail_count;

    int                 src_idle_pct = 0;
    int                 sink_stall_pct = 0;
    bit                 hold_request = 1'b0;
    int                 items_sent = 0;
    mwct_pkg::in_item_t set_q [$];
    int                 phase_terms [PHASES] = '{16, 3, 4, 31, 1, 0, 2, 9, 16};
    idle_mode_t         phase_idle [PHASES] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER,
                                                IDLE_BOTH, IDLE_NONE, IDLE_RECEIVER,
                                                IDLE_SENDER, IDLE_BOTH, IDLE_RECEIVER};

    min_window_covering_terms DUT (
        .aclk, .aresetn, .cfg_we, .cfg_wdata,
        .s_valid, .s_ready, .s_data,
        .m_valid, .m_ready, .m_data
    );

    window_checker u_checker (
        .aclk, .aresetn, .cfg_we, .cfg_wdata,
        .s_valid, .s_ready, .s_data,
        .m_valid, .m_ready, .m_data,
        .outstanding, .fail_count
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic add_req(input int t, input longint unsigned p, input bit last);
        mwct_pkg::in_item_t req;
        req.term         = t[mwct_pkg::TERM_BITS-1:0];
        req.position     = p[mwct_pkg::POSITION_BITS-1:0];
        req.last_of_term = last;
        set_q.push_back(req);
    endtask

    task automatic send_set();
        mwct_pkg::in_item_t req;
        while (set_q.size() != 0) begin
            req = set_q.pop_front();
            while ($urandom_range(99) < src_idle_pct) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
            s_valid <= 1'b1;
            s_data  <= req;
            do @(posedge aclk); while (!s_ready);
            items_sent++;
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_terms(input logic [mwct_pkg::TERM_COUNT_BITS-1:0] v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // One complete list set of k terms. Unsorted sets carry a serial number in
    // the low bits so that no two heads ever tie.
    task automatic build_random_set(input int k);
        int              pick;
        set_kind_t       kind;
        int              n;
        int              serial;
        int              idx;
        bit              wide;
        longint unsigned run_pos;
        longint unsigned pos;
        pick   = $urandom_range(99);
        kind   = (pick < 70) ? SET_SORTED : (pick < 82) ? SET_SCRAMBLED :
                 (pick < 92) ? SET_BAD_TERM : SET_NOISE;
        wide   = $urandom_range(1);
        serial = 0;
        for (int t = 0; t < k; t++) begin
            n = ($urandom_range(7) == 0) ? $urandom_range(40, 5) : $urandom_range(4, 1);
            run_pos = wide ? (longint'($urandom()) & MAX_POS) : longint'($urandom_range(1000));
            for (int i = 0; i < n; i++) begin
                if (kind == SET_SORTED || kind == SET_BAD_TERM) begin
                    pos = run_pos;
                    run_pos += wide ? longint'($urandom() >> $urandom_range(31, 4))
                                    : longint'($urandom_range(8));
                    if (run_pos > MAX_POS) run_pos = MAX_POS;
                end else begin
                    pos = {34'd0, 20'($urandom()), 10'(serial)};
                    serial++;
                end
                add_req((kind == SET_NOISE) ? $urandom_range(15) : t, pos, i == n - 1);
            end
        end
        if (kind == SET_BAD_TERM) begin
            idx = $urandom_range(set_q.size() - 1);
            set_q[idx].term = 4'($urandom_range(15));
        end
    endtask

    initial begin
        int k;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Single term at the reset count: lowest and highest positions.
        add_req(0, 0, 1);
        add_req(0, MAX_POS, 1);
        send_set();

        set_terms(2);
        // Widest possible window, tied heads, a skipped term, a falling list.
        add_req(0, 0, 1);
        add_req(1, MAX_POS, 1);
        add_req(0, 5, 0);
        add_req(0, 9, 1);
        add_req(1, 5, 0);
        add_req(1, 12, 1);
        add_req(1, 4, 1);
        add_req(1, 8, 1);
        add_req(0, 30, 0);
        add_req(0, 10, 1);
        add_req(1, 20, 1);
        send_set();

        set_terms(0);
        add_req(0, 7, 1);
        send_set();

        set_terms(31);
        for (int t = 0; t < mwct_pkg::MAX_TERMS_DEFAULT; t++)
            add_req(t, 3 * t, 1);
        send_set();

        for (int p = 0; p < PHASES; p++) begin
            set_terms(mwct_pkg::TERM_COUNT_BITS'(phase_terms[p]));
            k = (phase_terms[p] == 0) ? 1 :
                (phase_terms[p] > mwct_pkg::MAX_TERMS_DEFAULT) ? mwct_pkg::MAX_TERMS_DEFAULT
                                                                : phase_terms[p];
            case (phase_idle[p])
                IDLE_NONE: begin
                    src_idle_pct = 0;
                    sink_stall_pct = 0;
                end
                IDLE_SENDER: begin
                    src_idle_pct = 87;
                    sink_stall_pct = 0;
                end
                IDLE_RECEIVER: begin
                    src_idle_pct = 0;
                    sink_stall_pct = 87;
                end
                default: begin
                    src_idle_pct = 25;
                    sink_stall_pct = 25;
                end
            endcase
            if (p == 4) hold_request = 1'b1;
            if (p == 2) begin
                // Overfill the position store by two requests.
                for (int t = 0; t < k - 1; t++)
                    add_req(t, 100 * t, 1);
                for (int i = k - 1; i < mwct_pkg::STORE_DEPTH_DEFAULT + 2; i++)
                    add_req(k - 1, 5 * i, i == mwct_pkg::STORE_DEPTH_DEFAULT + 1);
                send_set();
            end
            items_sent = 0;
            while (items_sent < PHASE_ITEMS) begin
                build_random_set(k);
                send_set();
            end
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
